[src/sample_slice_ring_fifo_defines.svh]
// assertion macros for the sample slice ring fifo
`ifndef SAMPLE_SLICE_RING_FIFO_DEFINES_SVH
`define SAMPLE_SLICE_RING_FIFO_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ssrf_pkg.sv]
// types and constants shared by the sample slice ring fifo
package ssrf_pkg;

	localparam int FRAME_W  = 21;
	localparam int SAMPLE_W = 32;
	localparam int CH_W     = 7;
	localparam int WLEFT_W  = 27;
	localparam int DROP_W   = 64;
	localparam int WPROD_W  = FRAME_W + CH_W;
	localparam int HPROD_W  = SAMPLE_W + CH_W;
	localparam int CMP_W    = HPROD_W + 1;

	localparam logic [FRAME_W-1:0] FRAME_LIMIT     = FRAME_W'(1 << 20);
	localparam logic [FRAME_W-1:0] MAX_FRAMES_RST  = FRAME_W'(1024);

	typedef enum logic [2:0] {
		OP_WRITE_BEGIN  = 3'd0,
		OP_WRITE_SAMPLE = 3'd1,
		OP_READ_BEGIN   = 3'd2,
		OP_READ_SAMPLE  = 3'd3,
		OP_SKIP         = 3'd4,
		OP_PEEK         = 3'd5,
		OP_TAKE_DROPPED = 3'd6
	} op_t;

	typedef enum logic [0:0] {
		CFG_CHANNEL_COUNT = 1'b0,
		CFG_MAX_FRAMES    = 1'b1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_LOAD  = 5'b00100,
		S_HDEC  = 5'b01000,
		S_FETCH = 5'b10000
	} state_t;

	typedef struct packed {
		logic                accepted;
		logic [FRAME_W-1:0]  slice_frames;
		logic [SAMPLE_W-1:0] sample_out;
		logic                slice_last;
		logic [DROP_W-1:0]   dropped_total;
	} res_t;

endpackage

[src/ssrf_ram.sv]
// word ring store with one write port and one registered read port; one write and one read per cycle
module ssrf_ram import ssrf_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/sample_slice_ring_fifo.sv]
// top level of the sample slice ring fifo: control sequencer around the word store
//
//   channel   | handshake              | beat fields
//   ----------+------------------------+---------------------------------------------
//   command   | start, busy            | operation, frame_count, frame_capacity,
//             |                        | sample_in
//   result    | done (one-cycle pulse) | accepted, slice_frames, sample_out,
//             |                        | slice_last, dropped_total
//   config    | cfg_we                 | cfg_index, cfg_data
//
// a command is taken when start is high and busy low; write_begin, write_sample,
// read_sample and take_dropped pass through exec, peek through load, before done;
// busy drops in the cycle done is high, so the next command can be taken then.
// read_begin and skip pass through load and header-decode, ending in load on an
// empty ring; read_begin adds fetch, load and header-decode for each slice it drops:
// the registered store read and the header-length multiply set these states.
// arst_n clears pointers and counts and sets config to its defaults; no clearing pass over the store.
// the result side cannot stall: done is a pulse and must be taken.
`include "sample_slice_ring_fifo_defines.svh"

module sample_slice_ring_fifo import ssrf_pkg::*; #(
	parameter int RING_WORDS   = 4096,
	parameter int MAX_CHANNELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          operation,
	input  logic [FRAME_W-1:0]  frame_count,
	input  logic [FRAME_W-1:0]  frame_capacity,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [FRAME_W-1:0]  cfg_data,
	output logic                done,
	output logic                accepted,
	output logic [FRAME_W-1:0]  slice_frames,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                slice_last,
	output logic [DROP_W-1:0]   dropped_total
);

	localparam int AW = $clog2(RING_WORDS);
	localparam int PW = $clog2(2 * RING_WORDS);
	localparam logic [PW:0]   SPAN_P   = (PW + 1)'(2 * RING_WORDS);
	localparam logic [PW:0]   WORDS_P  = (PW + 1)'(RING_WORDS);
	localparam logic [PW-1:0] PTR_LAST = PW'(2 * RING_WORDS - 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_addr(input logic [PW-1:0] p);
		logic [PW:0] pe;
		pe = {1'b0, p};
		return (pe >= WORDS_P) ? AW'(pe - WORDS_P) : AW'(pe);
	endfunction

	state_t               state_q;
	logic [PW-1:0]        wp_q, rp_q, wcur_q, rcur_q;
	logic [WLEFT_W-1:0]   wwl_q, rwl_q;
	logic [DROP_W-1:0]    drop_q;
	logic [CH_W-1:0]      eff_ch_q;
	logic [FRAME_W-1:0]   eff_max_q;
	logic                 done_q;
	res_t                 res_q;

	logic [2:0]           op_q;
	logic [FRAME_W-1:0]   fc_q, cap_q;
	logic [SAMPLE_W-1:0]  smp_q;
	logic [WPROD_W-1:0]   wprod_q;
	logic [SAMPLE_W-1:0]  hdr_q;
	logic [HPROD_W-1:0]   hprod_q;

	logic [PW:0]          occ;
	logic                 wb_admit;
	logic                 hd_fits, hd_cap_ok;
	logic [PW:0]          skip_sum;
	logic [PW-1:0]        rp_skip;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [SAMPLE_W-1:0]  mem_wdata, mem_rdata;
	logic [CH_W-1:0]      cfg_ch;
	logic [FRAME_W-1:0]   cfg_max;

	ssrf_ram #(
		.DEPTH (RING_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		occ = ({1'b0, wp_q} >= {1'b0, rp_q}) ? ({1'b0, wp_q} - {1'b0, rp_q})
			: ({1'b0, wp_q} + SPAN_P - {1'b0, rp_q});
		wb_admit = (fc_q != '0) && (fc_q <= eff_max_q)
			&& ((CMP_W'(wprod_q) + CMP_W'(1)) <= (CMP_W'(WORDS_P) - CMP_W'(occ)));
		hd_fits   = (CMP_W'(hprod_q) + CMP_W'(1)) <= CMP_W'(occ);
		hd_cap_ok = hdr_q <= SAMPLE_W'(cap_q);
		skip_sum  = {1'b0, rp_q} + (PW + 1)'(1) + {1'b0, hprod_q[PW-1:0]};
		rp_skip   = (skip_sum >= SPAN_P) ? PW'(skip_sum - SPAN_P) : PW'(skip_sum);

		mem_we    = 1'b0;
		mem_waddr = ptr_addr(wp_q);
		mem_wdata = SAMPLE_W'(fc_q);
		if (state_q == S_EXEC) begin
			if (op_q == OP_WRITE_BEGIN && wb_admit) begin
				mem_we = 1'b1;
			end else if (op_q == OP_WRITE_SAMPLE && wwl_q != '0) begin
				mem_we    = 1'b1;
				mem_waddr = ptr_addr(wcur_q);
				mem_wdata = smp_q;
			end
		end

		mem_re    = (state_q == S_IDLE && start) || (state_q == S_FETCH);
		mem_raddr = (state_q == S_IDLE && operation == OP_READ_SAMPLE) ? ptr_addr(rcur_q)
			: ptr_addr(rp_q);

		// clamp register writes to their working range
		if (cfg_data[CH_W-1:0] == '0) begin
			cfg_ch = CH_W'(1);
		end else if (cfg_data[CH_W-1:0] > CH_W'(MAX_CHANNELS)) begin
			cfg_ch = CH_W'(MAX_CHANNELS);
		end else begin
			cfg_ch = cfg_data[CH_W-1:0];
		end
		cfg_max = (cfg_data > FRAME_LIMIT) ? FRAME_LIMIT : cfg_data;
	end

	// command latch and multiplies, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= operation;
			fc_q    <= frame_count;
			cap_q   <= frame_capacity;
			smp_q   <= sample_in;
			wprod_q <= WPROD_W'(frame_count) * WPROD_W'(eff_ch_q);
		end
		if (state_q == S_LOAD) begin
			hdr_q   <= mem_rdata;
			hprod_q <= HPROD_W'(mem_rdata) * HPROD_W'(eff_ch_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			wcur_q    <= '0;
			rcur_q    <= '0;
			wwl_q     <= '0;
			rwl_q     <= '0;
			drop_q    <= '0;
			eff_ch_q  <= CH_W'(1);
			eff_max_q <= MAX_FRAMES_RST;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CHANNEL_COUNT: eff_ch_q  <= cfg_ch;
					CFG_MAX_FRAMES:    eff_max_q <= cfg_max;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (operation == OP_READ_BEGIN || operation == OP_SKIP) begin
							rwl_q <= '0;
						end
						if (operation == OP_READ_BEGIN || operation == OP_SKIP
							|| operation == OP_PEEK) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end

				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					res_q   <= '0;
					unique case (op_q)
						OP_WRITE_BEGIN: begin
							wwl_q <= '0;
							if (wb_admit) begin
								wcur_q             <= ptr_inc(wp_q);
								wwl_q              <= wprod_q[WLEFT_W-1:0];
								res_q.accepted     <= 1'b1;
								res_q.slice_frames <= fc_q;
							end else begin
								drop_q <= drop_q + DROP_W'(fc_q);
							end
						end
						OP_WRITE_SAMPLE: begin
							if (wwl_q != '0) begin
								wcur_q         <= ptr_inc(wcur_q);
								wwl_q          <= wwl_q - WLEFT_W'(1);
								res_q.accepted <= 1'b1;
								if (wwl_q == WLEFT_W'(1)) begin
									wp_q             <= ptr_inc(wcur_q);
									res_q.slice_last <= 1'b1;
								end
							end
						end
						OP_READ_SAMPLE: begin
							if (rwl_q != '0) begin
								rcur_q           <= ptr_inc(rcur_q);
								rwl_q            <= rwl_q - WLEFT_W'(1);
								res_q.accepted   <= 1'b1;
								res_q.sample_out <= mem_rdata;
								if (rwl_q == WLEFT_W'(1)) begin
									rp_q             <= ptr_inc(rcur_q);
									res_q.slice_last <= 1'b1;
								end
							end
						end
						OP_TAKE_DROPPED: begin
							drop_q              <= '0;
							res_q.accepted      <= 1'b1;
							res_q.dropped_total <= drop_q;
						end
						default: ;
					endcase
				end

				S_LOAD: begin
					if (rp_q == wp_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '0;
					end else if (op_q == OP_PEEK) begin
						state_q            <= S_IDLE;
						done_q             <= 1'b1;
						res_q              <= '0;
						res_q.accepted     <= 1'b1;
						res_q.slice_frames <= mem_rdata[FRAME_W-1:0];
					end else begin
						state_q <= S_HDEC;
					end
				end

				S_HDEC: begin
					if (op_q == OP_READ_BEGIN && hd_cap_ok && hd_fits) begin
						rcur_q <= ptr_inc(rp_q);
						rwl_q  <= hprod_q[WLEFT_W-1:0];
						if (hprod_q == '0) begin
							rp_q <= ptr_inc(rp_q);
						end
						state_q            <= S_IDLE;
						done_q             <= 1'b1;
						res_q              <= '0;
						res_q.accepted     <= 1'b1;
						res_q.slice_frames <= hdr_q[FRAME_W-1:0];
					end else begin
						// drop the head slice, clamp to the write pointer if it overruns
						drop_q <= drop_q + DROP_W'(hdr_q);
						rp_q   <= hd_fits ? rp_skip : wp_q;
						if (op_q == OP_SKIP) begin
							state_q            <= S_IDLE;
							done_q             <= 1'b1;
							res_q              <= '0;
							res_q.accepted     <= 1'b1;
							res_q.slice_frames <= hdr_q[FRAME_W-1:0];
						end else begin
							state_q <= S_FETCH;
						end
					end
				end

				S_FETCH: begin
					state_q <= S_LOAD;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign accepted      = res_q.accepted;
	assign slice_frames  = res_q.slice_frames;
	assign sample_out    = res_q.sample_out;
	assign slice_last    = res_q.slice_last;
	assign dropped_total = res_q.dropped_total;

	`SSRF_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "command beat did not raise busy")
	`SSRF_ASSERT_NEXT(a_no_spurious_done, !busy && !start, !done, "result beat with no command")
	`SSRF_ASSERT_NOW(a_occ_bounded, 1'b1, occ <= WORDS_P, "ring occupancy above capacity")
	`SSRF_ASSERT_NOW(a_port_conflict, mem_we, !mem_re, "store written and read in one cycle")
	`SSRF_ASSERT_NOW(a_last_accepted, done && slice_last, accepted, "slice end on rejected beat")

endmodule
